[hw/rtl/mbps_pkg.sv]
// shared constants and types for the masked byte pattern search
package mbps_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int OFFSET_BITS_DEF       = 32;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;
	localparam int RES_OFFSET_W = 32;

	localparam logic [63:0] PATTERN_RESET = 64'h0;
	localparam logic [15:0] CARE_RESET    = 16'hFFFF;
	localparam logic [4:0]  LENGTH_RESET  = 5'd16;

	typedef enum logic [1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_CARE_MASK    = 2'd2,
		REG_PATTERN_LEN  = 2'd3
	} reg_index_t;

endpackage

[hw/rtl/masked_byte_pattern_search.sv]
// masked byte pattern search top level
//
// bytes of a region arrive on the s_ stream, one request per byte, s_tlast on
// the last byte. the block reports the first position where the configured
// pattern (up to 16 bytes, per-byte care mask) matches the recent bytes.
// a result on the m_ stream is either found (m_tuser high, m_tdata = start
// offset of the match in the region) or not-found at the end of a region with
// no match (m_tuser low, m_tdata zero). at most one result per region.
// an accepted byte is held in an input register, then the window shift and
// the parallel masked compare run combinationally into the result register.
// one byte is taken every cycle while no result waits on a low m_tready; when
// one does, the result register holds and the input register fills, after
// which s_tready drops until the result leaves. reset clears the region state
// (byte count, found flag) and the registers return to pattern zero, all
// bytes cared, length 16. the region state also clears after every last byte.
// the user writes configuration over the apb port at byte addresses 0, 8, 16
// and 24 while the stream is idle; the block does not enforce this.
module masked_byte_pattern_search #(
	parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mbps_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	// byte input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tlast,   // region_end
	// result output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // match_offset
	output logic                            m_tuser    // found
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	// configuration registers
	logic [63:0] pattern_low_q;
	logic [63:0] pattern_high_q;
	logic [15:0] care_mask_q;
	logic [4:0]  pattern_length_q;

	logic        cfg_write;
	logic [1:0]  cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= mbps_pkg::PATTERN_RESET;
			pattern_high_q   <= mbps_pkg::PATTERN_RESET;
			care_mask_q      <= mbps_pkg::CARE_RESET;
			pattern_length_q <= mbps_pkg::LENGTH_RESET;
		end else if (cfg_write) begin
			unique case (mbps_pkg::reg_index_t'(cfg_index))
				mbps_pkg::REG_PATTERN_LOW:  pattern_low_q    <= pwdata;
				mbps_pkg::REG_PATTERN_HIGH: pattern_high_q   <= pwdata;
				mbps_pkg::REG_CARE_MASK:    care_mask_q      <= pwdata[15:0];
				mbps_pkg::REG_PATTERN_LEN:  pattern_length_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (mbps_pkg::reg_index_t'(cfg_index))
			mbps_pkg::REG_PATTERN_LOW:  prdata = pattern_low_q;
			mbps_pkg::REG_PATTERN_HIGH: prdata = pattern_high_q;
			mbps_pkg::REG_CARE_MASK:    prdata = {48'h0, care_mask_q};
			mbps_pkg::REG_PATTERN_LEN:  prdata = {59'h0, pattern_length_q};
			default:                    prdata = '0;
		endcase
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// region state
	logic [7:0]             window_q [MAX_PATTERN_BYTES];
	logic [7:0]             window_next [MAX_PATTERN_BYTES];
	logic [OFFSET_BITS-1:0] count_q;
	logic [OFFSET_BITS-1:0] count_next;
	logic [OFFSET_BITS-1:0] offset_full;
	logic                   reported_q;

	logic [127:0]   pattern_all;
	logic [LEN_W-1:0] len_u;
	logic [IDX_W-1:0] idx;
	logic           window_hit;
	logic           hit;
	logic           has_result;

	// result register
	logic        m_valid_q;
	logic        found_q;
	logic [31:0] offset_q;

	assign advance     = valid_s1 && (!m_valid_q || m_tready);
	assign pattern_all = {pattern_high_q, pattern_low_q};

	always_comb begin
		if (pattern_length_q == 5'd0) begin
			len_u = LEN_W'(1);
		end else if (pattern_length_q > 5'(MAX_PATTERN_BYTES)) begin
			len_u = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_u = LEN_W'(pattern_length_q);
		end
	end

	always_comb begin
		window_next[0] = byte_s1;
		for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
			window_next[j] = window_q[j-1];
		end
	end

	assign count_next  = (count_q == '1) ? count_q : count_q + 1'b1;
	assign offset_full = count_next - OFFSET_BITS'(len_u);

	// masked compare, pattern byte k against window entry len-1-k
	always_comb begin
		window_hit = 1'b1;
		idx        = '0;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			idx = IDX_W'(int'(len_u) - 1 - k);
			if ((k < int'(len_u)) && care_mask_q[k] &&
			    (window_next[idx] != pattern_all[8*k +: 8])) begin
				window_hit = 1'b0;
			end
		end
	end

	assign hit        = !reported_q && (count_next >= OFFSET_BITS'(len_u)) && window_hit;
	assign has_result = hit || (last_s1 && !reported_q);

	always_ff @(posedge clk) begin
		if (advance) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				count_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				count_q <= count_next;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= has_result;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			found_q  <= hit;
			offset_q <= hit ? 32'(offset_full) : 32'h0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = offset_q;

endmodule

[test/search_checker.sv]
// checker that mirrors the registers, predicts each search result and compares
module search_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tlast,   // region_end
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [31:0]                     m_tdata,   // match_offset
	input  logic                            m_tuser,   // found
	output int                              mismatches,
	output int                              outstanding,
	output int                              hits,
	output int                              misses
);

	typedef struct packed {
		logic        found;
		logic [31:0] offset;
	} search_result_t;

	logic [63:0] pat_low;
	logic [63:0] pat_high;
	logic [15:0] care;
	logic [4:0]  pat_len;
	logic [7:0]  window [mbps_pkg::MAX_PATTERN_BYTES_DEF];
	logic [31:0] seen;
	logic        reported;
	search_result_t expected_q [$];

	function automatic logic [7:0] pattern_at(input int k);
		if (k < 8)
			return pat_low[8*k +: 8];
		return pat_high[8*(k-8) +: 8];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		$display("%0t checker: %s expected %0h got %0h", $time, what, want, got);
	endtask

	task automatic clear_region();
		for (int i = 0; i < mbps_pkg::MAX_PATTERN_BYTES_DEF; i++)
			window[i] = 8'h00;
		seen = '0;
		reported = 1'b0;
	endtask

	// shift the byte in, then look for the first match or the end of the region
	task automatic search_step(input logic [7:0] b, input logic last);
		int unsigned len;
		logic hit;
		for (int i = mbps_pkg::MAX_PATTERN_BYTES_DEF - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = b;
		if (seen != '1)
			seen++;
		len = (pat_len == 0) ? 1 : (pat_len > mbps_pkg::MAX_PATTERN_BYTES_DEF) ?
			mbps_pkg::MAX_PATTERN_BYTES_DEF : pat_len;
		if (!reported && seen >= len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++)
				if (care[k] && window[len-1-k] != pattern_at(k))
					hit = 1'b0;
			if (hit) begin
				reported = 1'b1;
				expected_q.insert(expected_q.size(),
					search_result_t'{1'b1, 32'(seen - len)});
			end
		end
		if (last) begin
			if (!reported)
				expected_q.insert(expected_q.size(), search_result_t'{1'b0, 32'd0});
			clear_region();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		search_result_t want;
		if (!arst_n) begin
			pat_low = mbps_pkg::PATTERN_RESET;
			pat_high = mbps_pkg::PATTERN_RESET;
			care = mbps_pkg::CARE_RESET;
			pat_len = mbps_pkg::LENGTH_RESET;
			clear_region();
			expected_q.delete();
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (mbps_pkg::reg_index_t'(paddr[mbps_pkg::CFG_ADDR_W-1:3]))
					mbps_pkg::REG_PATTERN_LOW:  pat_low = pwdata;
					mbps_pkg::REG_PATTERN_HIGH: pat_high = pwdata;
					mbps_pkg::REG_CARE_MASK:    care = pwdata[15:0];
					mbps_pkg::REG_PATTERN_LEN:  pat_len = pwdata[4:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with none pending, offset", 32'd0, m_tdata);
				end else begin
					want = expected_q.pop_front();
					if (m_tuser !== want.found)
						report_mismatch("found flag", 32'(want.found), 32'(m_tuser));
					if (m_tdata !== want.offset)
						report_mismatch("match offset", want.offset, m_tdata);
					if (want.found)
						hits++;
					else
						misses++;
				end
			end
			if (s_tvalid && s_tready)
				search_step(s_tdata, s_tlast);
			outstanding = expected_q.size();
		end
	end

endmodule

[test/tb.sv]
// testbench top: byte regions and register settings for the masked pattern search
module tb;

	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int PHASE_ITEMS   = 160;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [mbps_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [mbps_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [mbps_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata = '0;   // data_byte
	logic                            s_tlast = 1'b0; // region_end
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [31:0]                     m_tdata;        // match_offset
	logic                            m_tuser;        // found

	int mismatches;
	int outstanding;
	int hits;
	int misses;

	logic        steady = 1'b0;
	int          idle_cycles = 0;
	int          sent_bytes = 0;
	int          regions = 0;
	int          settings = 0;
	logic [127:0] cfg_pattern = '0;
	logic [15:0]  cfg_care = mbps_pkg::CARE_RESET;
	int unsigned  eff_len = mbps_pkg::MAX_PATTERN_BYTES_DEF;

	masked_byte_pattern_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	search_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.hits        (hits),
		.misses      (misses)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 38);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic apb_write(input mbps_pkg::reg_index_t idx,
			input logic [mbps_pkg::CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// unused upper bits of the narrow registers carry junk
	task automatic configure(input logic [63:0] low, input logic [63:0] high,
			input logic [15:0] care, input logic [4:0] len);
		apb_write(mbps_pkg::REG_PATTERN_LOW, low);
		apb_write(mbps_pkg::REG_PATTERN_HIGH, high);
		apb_write(mbps_pkg::REG_CARE_MASK, {$urandom, 16'($urandom), care});
		apb_write(mbps_pkg::REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_pattern = {high, low};
		cfg_care = care;
		eff_len = (len == 0) ? 1 : (len > mbps_pkg::MAX_PATTERN_BYTES_DEF) ?
			mbps_pkg::MAX_PATTERN_BYTES_DEF : len;
		settings++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!steady && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 38);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_bytes++;
	endtask

	// wait for every pending result, then let the pipeline drain
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: return cfg_pattern[8*$urandom_range(0, 15) +: 8];
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// region with a planted pattern, a planted near miss, or noise only
	task automatic send_region(input int unsigned n);
		logic [7:0] region_bytes [$];
		int unsigned mode;
		int unsigned at;
		int unsigned k;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < n; i++)
			region_bytes.insert(region_bytes.size(), noise_byte());
		if (mode < 7 && n >= eff_len) begin
			at = $urandom_range(0, n - eff_len);
			for (int j = 0; j < eff_len; j++)
				if (cfg_care[j])
					region_bytes[at+j] = cfg_pattern[8*j +: 8];
			if (mode >= 5) begin
				k = $urandom_range(0, eff_len - 1);
				region_bytes[at+k] = region_bytes[at+k] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (int i = 0; i < n; i++)
			send_byte(region_bytes[i], i == n - 1);
		regions++;
	endtask

	initial begin
		int phase;
		int phase_start;
		logic [4:0] len;
		logic [15:0] care;
		int unsigned n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: region shorter than the pattern
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		settle();

		// zero length acts as one; bytes after a match; match on the last byte
		configure(64'h0123_4567_89AB_CDFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 5'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h7F, 1'b1);
		settle();

		// oversized length acts as sixteen, only the top pattern byte cared
		configure(64'h0, 64'hA500_0000_0000_0000, 16'h8000, 5'd31);
		for (int i = 0; i < 15; i++)
			send_byte(8'($urandom), 1'b0);
		send_byte(8'hA5, 1'b1);
		settle();

		phase = 0;
		while (sent_bytes < 24 + RANDOM_ITEMS) begin
			case (phase % 6)
				0: len = 5'd1;
				1: len = 5'd16;
				2: len = 5'd0;
				3: len = 5'($urandom_range(17, 31));
				default: len = 5'($urandom_range(1, 16));
			endcase
			if (phase % 7 == 5)
				care = 16'h0000;
			else if ($urandom_range(0, 2) == 0)
				care = 16'hFFFF;
			else
				care = 16'($urandom);
			configure({$urandom, $urandom}, {$urandom, $urandom}, care, len);
			steady <= (phase == 3);
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 39) == 0)
					n = $urandom_range(100, 400);
				else
					n = $urandom_range(1, eff_len + 12);
				send_region(n);
			end
			settle();
			phase++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		$display("tb: %0d bytes in %0d regions under %0d register settings",
			sent_bytes, regions, settings);
		$display("tb: %0d matches and %0d not-found results compared", hits, misses);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
